// ===== rtl/core/rmq_pkg.sv =====
package rmq_pkg;

    localparam int WORD_BITS = 16;
    localparam int FRAC_BITS = 14;

    // signed trace / root argument
    localparam int ARG_W   = WORD_BITS + 3;
    // radicand arg << FRAC_BITS, padded to an even width
    localparam int RAD_RAW = WORD_BITS + 2 + FRAC_BITS;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int SQ_IT   = ROOT_W;
    localparam int SQ_ST   = (SQ_IT + 1) / 2;
    // off-diagonal magnitude and dividend (mag << FRAC_BITS) + s
    localparam int MAG_W   = WORD_BITS + 1;
    localparam int NUM_W   = WORD_BITS + FRAC_BITS + 1;
    localparam int DV_IT   = WORD_BITS;
    localparam int DV_ST   = (DV_IT + 1) / 2;
    localparam int NST     = SQ_ST + DV_ST + 2;

    typedef logic [1:0] branch_t;

    localparam branch_t BR_TRACE = 2'd0;
    localparam branch_t BR_X     = 2'd1;
    localparam branch_t BR_Y     = 2'd2;
    localparam branch_t BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] col0_row0;
        logic signed [WORD_BITS-1:0] col0_row1;
        logic signed [WORD_BITS-1:0] col0_row2;
        logic signed [WORD_BITS-1:0] col1_row0;
        logic signed [WORD_BITS-1:0] col1_row1;
        logic signed [WORD_BITS-1:0] col1_row2;
        logic signed [WORD_BITS-1:0] col2_row0;
        logic signed [WORD_BITS-1:0] col2_row1;
        logic signed [WORD_BITS-1:0] col2_row2;
    } mat_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] quat_x;
        logic signed [WORD_BITS-1:0] quat_y;
        logic signed [WORD_BITS-1:0] quat_z;
        logic signed [WORD_BITS-1:0] quat_w;
        branch_t                     branch_taken;
        logic                        invalid;
    } quat_t;

    // per-item state carried down the pipeline
    typedef struct packed {
        branch_t                             branch;
        logic [1:0]                          half;
        logic                                bad;
        logic [3:0]                          neg;
        logic [3:0][MAG_W-1:0]               mag;
        logic [RAD_W-1:0]                    rad;
        logic [REM_W-1:0]                    srem;
        logic [ROOT_W-1:0]                   root;
        logic [3:0][NUM_W-1:0]               drem;
        logic [3:0][WORD_BITS-1:0]           quo;
    } pl_t;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Channel  Signals                        Payload
// -------  -----------------------------  ------------------------------------
// mat      mat_valid / mat_ready / mat    nine signed Q2.14 matrix entries
// quat     quat_valid / quat_ready / quat x, y, z, w, branch_taken, invalid
//
// With Q2.14 words the pipeline has one front-end stage, SQ_ST square root
// stages, one divide setup stage, DV_ST divide stages and one output stage.
// One beat per cycle is accepted while quat_ready is high.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// A stall on quat freezes the whole pipeline, so mat_ready follows quat_ready
// whenever the output register holds a beat.
module rotation_matrix_to_quaternion (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mat_valid,
    output logic          mat_ready,
    input  rmq_pkg::mat_t mat,
    output logic          quat_valid,
    input  logic          quat_ready,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) <<< FRAC_BITS;
    localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    pl_t             stg_reg  [NST];
    pl_t             stg_next [NST];
    logic [NST-1:0]  vld_reg;
    logic [NST-1:0]  vld_next;
    quat_t           quat_reg;
    quat_t           quat_next;
    logic            quat_valid_reg;
    logic            quat_valid_next;
    logic            adv;

    // Branch select, root argument and off-diagonal terms.
    function automatic pl_t front(mat_t m);
        logic signed [ARG_W-1:0] e [9];
        logic signed [ARG_W-1:0] nm [4];
        logic signed [ARG_W-1:0] tr;
        logic signed [ARG_W-1:0] arg;
        logic [1:0]              dom;
        pl_t                     p;
        e[0] = ARG_W'(m.col0_row0);
        e[1] = ARG_W'(m.col0_row1);
        e[2] = ARG_W'(m.col0_row2);
        e[3] = ARG_W'(m.col1_row0);
        e[4] = ARG_W'(m.col1_row1);
        e[5] = ARG_W'(m.col1_row2);
        e[6] = ARG_W'(m.col2_row0);
        e[7] = ARG_W'(m.col2_row1);
        e[8] = ARG_W'(m.col2_row2);
        p = '0;
        for (int k = 0; k < 4; k++) nm[k] = '0;
        tr = e[0] + e[4] + e[8];
        if (tr >= 0)
        begin
            p.branch = BR_TRACE;
            p.half   = 2'd3;
            arg      = tr + ONE;
            nm[0]    = e[5] - e[7];
            nm[1]    = e[6] - e[2];
            nm[2]    = e[1] - e[3];
        end
        else
        begin
            dom = 2'd0;
            if (e[4] > e[0]) dom = 2'd1;
            if (e[8] > ((dom == 2'd1) ? e[4] : e[0])) dom = 2'd2;
            p.half = dom;
            case (dom)
                2'd0:
                begin
                    p.branch = BR_X;
                    arg      = e[0] - (e[4] + e[8]) + ONE;
                    nm[1]    = e[3] + e[1];
                    nm[2]    = e[2] + e[6];
                    nm[3]    = e[5] - e[7];
                end
                2'd1:
                begin
                    p.branch = BR_Y;
                    arg      = e[4] - (e[8] + e[0]) + ONE;
                    nm[0]    = e[3] + e[1];
                    nm[2]    = e[7] + e[5];
                    nm[3]    = e[6] - e[2];
                end
                default:
                begin
                    p.branch = BR_Z;
                    arg      = e[8] - (e[0] + e[4]) + ONE;
                    nm[0]    = e[2] + e[6];
                    nm[1]    = e[7] + e[5];
                    nm[3]    = e[1] - e[3];
                end
            endcase
        end
        p.bad = (arg <= 0);
        for (int k = 0; k < 4; k++)
        begin
            p.neg[k] = nm[k][ARG_W-1];
            p.mag[k] = nm[k][ARG_W-1] ? MAG_W'(-nm[k]) : MAG_W'(nm[k]);
        end
        p.rad = p.bad ? '0 : (RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS);
        return p;
    endfunction

    // One digit of the restoring square root.
    function automatic pl_t sq_step(pl_t pi);
        logic [REM_W+1:0] r;
        logic [REM_W+1:0] t;
        pl_t              p;
        p = pi;
        r = {p.srem, p.rad[RAD_W-1 -: 2]};
        t = {2'b00, p.root, 2'b01};
        if (r >= t)
        begin
            p.srem = REM_W'(r - t);
            p.root = {p.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            p.srem = REM_W'(r);
            p.root = {p.root[ROOT_W-2:0], 1'b0};
        end
        p.rad = p.rad << 2;
        return p;
    endfunction

    function automatic pl_t dv_setup(pl_t pi);
        pl_t p;
        p = pi;
        for (int k = 0; k < 4; k++)
        begin
            p.drem[k] = (NUM_W'(p.mag[k]) << FRAC_BITS) + NUM_W'(p.root);
            p.quo[k]  = '0;
        end
        return p;
    endfunction

    // One quotient bit in every lane; the top bit flags saturation.
    function automatic pl_t dv_step(pl_t pi, int bitpos);
        logic [NUM_W-1:0] dv;
        pl_t              p;
        p  = pi;
        dv = NUM_W'({p.root, 1'b0});
        for (int k = 0; k < 4; k++)
        begin
            if ((p.drem[k] >> bitpos) >= dv)
            begin
                p.drem[k]        = p.drem[k] - (dv << bitpos);
                p.quo[k][bitpos] = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic quat_t finish(pl_t p);
        logic [ROOT_W-1:0]          hv;
        logic [3:0][WORD_BITS-1:0]  c;
        quat_t                      q;
        hv = ROOT_W'(({1'b0, p.root} + (ROOT_W+1)'(1)) >> 1);
        for (int k = 0; k < 4; k++)
        begin
            if (p.bad)
                c[k] = '0;
            else if (k == int'(p.half))
                c[k] = ((hv >> (WORD_BITS-1)) != '0) ? WMAX : WORD_BITS'(hv);
            else if (p.quo[k][WORD_BITS-1])
                c[k] = p.neg[k] ? WMIN : WMAX;
            else
                c[k] = p.neg[k] ? -p.quo[k] : p.quo[k];
        end
        q.quat_x       = c[0];
        q.quat_y       = c[1];
        q.quat_z       = c[2];
        q.quat_w       = c[3];
        q.branch_taken = p.branch;
        q.invalid      = p.bad;
        return q;
    endfunction

    // Whole-pipeline advance: free or being drained.
    assign adv       = !quat_valid_reg || quat_ready;
    assign mat_ready = adv;

    // Stage map: 0 front end, 1..SQ_ST root, SQ_ST+1 divide setup,
    // then DV_ST divide stages.
    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        always_comb
        begin
            pl_t p;
            if (g == 0)
                p = front(mat);
            else
                p = stg_reg[(g == 0) ? 0 : g-1];
            if (g >= 1 && g <= SQ_ST)
            begin
                if (2*(g-1) < SQ_IT)     p = sq_step(p);
                if (2*(g-1) + 1 < SQ_IT) p = sq_step(p);
            end
            else if (g == SQ_ST + 1)
            begin
                p = dv_setup(p);
            end
            else if (g > SQ_ST + 1)
            begin
                if (2*(g-SQ_ST-2) < DV_IT)
                    p = dv_step(p, WORD_BITS-1-2*(g-SQ_ST-2));
                if (2*(g-SQ_ST-2) + 1 < DV_IT)
                    p = dv_step(p, WORD_BITS-2-2*(g-SQ_ST-2));
            end
            stg_next[g] = p;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[g] <= stg_next[g];
            end
        end
    end

    assign vld_next        = {vld_reg[NST-2:0], mat_valid};
    assign quat_valid_next = vld_reg[NST-1];
    assign quat_next       = finish(stg_reg[NST-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            quat_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg        <= vld_next;
            quat_valid_reg <= quat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quat_reg <= quat_next;
        end
    end

    assign quat_valid = quat_valid_reg;
    assign quat       = quat_reg;

endmodule
